// File: rtl/markup_tag_nesting_checker_assert.svh
`ifndef MARKUP_TAG_NESTING_CHECKER_ASSERT_SVH
`define MARKUP_TAG_NESTING_CHECKER_ASSERT_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define MTNC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtnc check failed");

// next-cycle implication, checked on clk, off while rst_n is low
`define MTNC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtnc check failed");

`endif

// File: rtl/mtnc_pkg.sv
package mtnc_pkg;

  localparam int STACK_DEPTH  = 32;
  localparam int MAX_NAME_LEN = 9;

  localparam int CHAR_W   = 8;
  localparam int ERR_W    = 3;
  localparam int LETTER_W = 5;
  localparam int LEN_W    = $clog2(MAX_NAME_LEN + 1);
  localparam int SLOT_W   = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
  localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PFX_LEN  = 8;
  localparam int PFX_W    = 4;

  localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
  localparam logic [CHAR_W-1:0] CH_RBRK  = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;

  typedef enum logic [2:0] {
    MODE_START,
    MODE_LT,
    MODE_OPEN,
    MODE_CLOSE,
    MODE_PREFIX,
    MODE_CDATA,
    MODE_TEXT
  } mode_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE,
    ERR_TAG,
    ERR_CLOSE,
    ERR_CDATA,
    ERR_UNCLOSED,
    ERR_OVERFLOW,
    ERR_OUTSIDE
  } err_t;

  typedef logic [MAX_NAME_LEN-1:0][LETTER_W-1:0] name_t;

  typedef struct packed {
    name_t            name;
    logic [LEN_W-1:0] len;
  } stack_entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    stack_entry_t     data;
  } stk_wr_t;

  typedef struct packed {
    logic valid_res;
    err_t error_kind;
  } verdict_t;

  // "![CDATA[" one byte per position
  function automatic logic [CHAR_W-1:0] prefix_char(input logic [PFX_W-1:0] idx);
    logic [CHAR_W-1:0] ch;
    case (idx)
      4'd0:    ch = 8'h21;
      4'd1:    ch = 8'h5B;
      4'd2:    ch = 8'h43;
      4'd3:    ch = 8'h44;
      4'd4:    ch = 8'h41;
      4'd5:    ch = 8'h54;
      4'd6:    ch = 8'h41;
      4'd7:    ch = 8'h5B;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/mtnc_if.sv
interface mtnc_in_if;
  logic                        valid;
  logic                        ready;
  logic [mtnc_pkg::CHAR_W-1:0] char_in;
  logic                        last;

  modport source (output valid, output char_in, output last, input ready);
  modport sink   (input valid, input char_in, input last, output ready);
endinterface

interface mtnc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       valid_res;
  logic [mtnc_pkg::ERR_W-1:0] error_kind;

  modport source (output valid, output valid_res, output error_kind, input ready);
  modport sink   (input valid, input valid_res, input error_kind, output ready);
endinterface

// File: rtl/mtnc_stack.sv
module mtnc_stack (
  input  logic                         clk,
  input  mtnc_pkg::stk_wr_t            wr,
  input  logic [mtnc_pkg::IDX_W-1:0]   rd_addr,
  output mtnc_pkg::stack_entry_t       top
);
  import mtnc_pkg::*;

  stack_entry_t mem [STACK_DEPTH];
  stack_entry_t top_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read, new word forwarded when it lands on the read address
  always_ff @(posedge clk) begin
    if (wr.we && (wr.addr == rd_addr)) begin
      top_r <= wr.data;
    end else begin
      top_r <= mem[rd_addr];
    end
  end

  assign top = top_r;

endmodule

// File: rtl/mtnc_parser.sv
module mtnc_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [mtnc_pkg::CHAR_W-1:0]   char_in,
  input  logic                          last,
  input  mtnc_pkg::stack_entry_t        top,
  output mtnc_pkg::stk_wr_t             stk_wr,
  output logic [mtnc_pkg::IDX_W-1:0]    rd_addr,
  output mtnc_pkg::verdict_t            verdict
);
  import mtnc_pkg::*;

  `include "markup_tag_nesting_checker_assert.svh"

  mode_t             mode_r,  mode_nxt,  mode_stp;
  err_t              err_r,   err_nxt,   err_stp;
  logic [CNT_W-1:0]  count_r, count_nxt, count_stp;
  name_t             name_r,  name_nxt,  name_stp;
  logic [LEN_W-1:0]  len_r,   len_nxt,   len_stp;
  logic [PFX_W-1:0]  pfx_r,   pfx_nxt,   pfx_stp;
  logic [1:0]        brk_r,   brk_nxt,   brk_stp;
  logic              root_r,  root_nxt,  root_stp;
  logic              is_upper;
  logic              top_match;

  assign is_upper  = (char_in >= CH_A) && (char_in <= CH_Z);
  assign top_match = (top.len == len_r) && (top.name == name_r);

  // effect of one byte on the parse state
  always_comb begin
    mode_stp  = mode_r;
    err_stp   = err_r;
    count_stp = count_r;
    name_stp  = name_r;
    len_stp   = len_r;
    pfx_stp   = pfx_r;
    brk_stp   = brk_r;
    root_stp  = root_r;
    stk_wr    = '0;
    if (err_r == ERR_NONE) begin
      case (mode_r)
        MODE_START: begin
          if (char_in == CH_LT) begin
            mode_stp = MODE_LT;
          end else begin
            err_stp = ERR_OUTSIDE;
          end
        end
        MODE_LT: begin
          name_stp = '0;
          len_stp  = '0;
          if (is_upper) begin
            mode_stp    = MODE_OPEN;
            name_stp[0] = char_in[LETTER_W-1:0];
            len_stp     = LEN_W'(1);
          end else if (char_in == CH_SLASH) begin
            mode_stp = MODE_CLOSE;
          end else if (char_in == CH_BANG) begin
            if (count_r == '0) begin
              err_stp = ERR_OUTSIDE;
            end else begin
              mode_stp = MODE_PREFIX;
              pfx_stp  = PFX_W'(1);
            end
          end else begin
            err_stp = ERR_TAG;
          end
        end
        MODE_OPEN, MODE_CLOSE: begin
          if (is_upper) begin
            if (len_r >= LEN_W'(MAX_NAME_LEN)) begin
              err_stp = ERR_TAG;
            end else begin
              name_stp[len_r[SLOT_W-1:0]] = char_in[LETTER_W-1:0];
              len_stp = len_r + LEN_W'(1);
            end
          end else if (char_in == CH_GT) begin
            if (len_r == '0) begin
              err_stp = ERR_TAG;
            end else if (mode_r == MODE_OPEN) begin
              if (count_r >= CNT_W'(STACK_DEPTH)) begin
                err_stp = ERR_OVERFLOW;
              end else begin
                stk_wr.we       = 1'b1;
                stk_wr.addr     = count_r[IDX_W-1:0];
                stk_wr.data     = '{name: name_r, len: len_r};
                count_stp       = count_r + CNT_W'(1);
                mode_stp        = MODE_TEXT;
              end
            end else begin
              if (count_r == '0 || !top_match) begin
                err_stp = ERR_CLOSE;
              end else begin
                count_stp = count_r - CNT_W'(1);
                if (count_r == CNT_W'(1)) begin
                  root_stp = 1'b1;
                end
                mode_stp = MODE_TEXT;
              end
            end
          end else begin
            err_stp = ERR_TAG;
          end
        end
        MODE_PREFIX: begin
          if (pfx_r < PFX_W'(PFX_LEN) && char_in == prefix_char(pfx_r)) begin
            pfx_stp = pfx_r + PFX_W'(1);
            if (pfx_r == PFX_W'(PFX_LEN - 1)) begin
              mode_stp = MODE_CDATA;
              brk_stp  = '0;
            end
          end else begin
            err_stp = ERR_TAG;
          end
        end
        MODE_CDATA: begin
          if (char_in == CH_RBRK) begin
            if (brk_r < 2'd2) begin
              brk_stp = brk_r + 2'd1;
            end
          end else if (char_in == CH_GT && brk_r == 2'd2) begin
            brk_stp  = '0;
            mode_stp = MODE_TEXT;
          end else begin
            brk_stp = '0;
          end
        end
        default: begin
          if (root_r) begin
            err_stp = ERR_OUTSIDE;
          end else if (char_in == CH_LT) begin
            mode_stp = MODE_LT;
          end
        end
      endcase
    end
  end

  // verdict on the final byte, and the stack read address for the next byte
  always_comb begin
    verdict.error_kind = err_stp;
    if (err_stp == ERR_NONE) begin
      if (mode_stp == MODE_CDATA) begin
        verdict.error_kind = ERR_CDATA;
      end else if (mode_stp != MODE_TEXT) begin
        verdict.error_kind = ERR_TAG;
      end else if (!root_stp) begin
        verdict.error_kind = ERR_UNCLOSED;
      end
    end
    verdict.valid_res = (verdict.error_kind == ERR_NONE);
    rd_addr = IDX_W'(count_nxt - CNT_W'(1));
  end

  always_comb begin
    mode_nxt  = mode_r;
    err_nxt   = err_r;
    count_nxt = count_r;
    name_nxt  = name_r;
    len_nxt   = len_r;
    pfx_nxt   = pfx_r;
    brk_nxt   = brk_r;
    root_nxt  = root_r;
    if (go && last) begin
      mode_nxt  = MODE_START;
      err_nxt   = ERR_NONE;
      count_nxt = '0;
      name_nxt  = '0;
      len_nxt   = '0;
      pfx_nxt   = '0;
      brk_nxt   = '0;
      root_nxt  = 1'b0;
    end else if (go) begin
      mode_nxt  = mode_stp;
      err_nxt   = err_stp;
      count_nxt = count_stp;
      name_nxt  = name_stp;
      len_nxt   = len_stp;
      pfx_nxt   = pfx_stp;
      brk_nxt   = brk_stp;
      root_nxt  = root_stp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_START;
      err_r   <= ERR_NONE;
      count_r <= '0;
      name_r  <= '0;
      len_r   <= '0;
      pfx_r   <= '0;
      brk_r   <= '0;
      root_r  <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      err_r   <= err_nxt;
      count_r <= count_nxt;
      name_r  <= name_nxt;
      len_r   <= len_nxt;
      pfx_r   <= pfx_nxt;
      brk_r   <= brk_nxt;
      root_r  <= root_nxt;
    end
  end

  `MTNC_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(STACK_DEPTH))
  `MTNC_ASSERT_NOW(a_push_room, stk_wr.we, count_r < CNT_W'(STACK_DEPTH))
  `MTNC_ASSERT_NOW(a_root_empty, root_r, count_r == '0)
  `MTNC_ASSERT_NEXT(a_verdict_clears, go && last, count_r == '0 && err_r == ERR_NONE)
  `MTNC_ASSERT_NEXT(a_error_freezes, err_r != ERR_NONE && !(go && last), $stable(count_r))

endmodule

// File: rtl/markup_tag_nesting_checker.sv
// Markup tag nesting checker: takes a code string one byte per word on in_ch
// (last marks the final byte) and returns one verdict word on out_ch for each
// string, valid_res = 1 when the string is exactly one closed root tag, else
// error_kind gives the first fault (1 bad tag, 2 bad close, 3 open cdata,
// 4 unclosed, 5 overflow, 6 outside root). A new byte is taken every clock,
// one word per cycle sustained while no final byte waits on an unread verdict;
// the verdict reaches out_ch through the input register, which holds the byte
// while the single parse stage works on it, and the result register, which
// loads when the parse stage takes the final byte. A final byte waits in the
// input register while the previous verdict is still unread, and in_ch.ready
// stays low until out_ch takes that verdict. The tag stack (32 names) sits in a
// memory whose top word is read registered in the cycle that changes the
// depth, so it is ready for the next end tag. No clearing pass after reset.
module markup_tag_nesting_checker (
  input  logic        clk,
  input  logic        rst_n,
  mtnc_in_if.sink     in_ch,
  mtnc_out_if.source  out_ch
);
  import mtnc_pkg::*;

  // input register
  logic              in_vld_r;
  logic [CHAR_W-1:0] in_char_r;
  logic              in_last_r;

  // result register
  logic              out_vld_r;
  verdict_t          out_res_r;

  logic              go;
  stk_wr_t           stk_wr;
  logic [IDX_W-1:0]  rd_addr;
  stack_entry_t      top;
  verdict_t          verdict;

  // a byte without last never needs the result slot, so it always moves on
  assign go          = in_vld_r && (!in_last_r || !out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_char_r <= in_ch.char_in;
      in_last_r <= in_ch.last;
    end
  end

  mtnc_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .char_in (in_char_r),
    .last    (in_last_r),
    .top     (top),
    .stk_wr  (stk_wr),
    .rd_addr (rd_addr),
    .verdict (verdict)
  );

  mtnc_stack u_stack (
    .clk     (clk),
    .wr      (stk_wr),
    .rd_addr (rd_addr),
    .top     (top)
  );

  // result slot: loads on the final byte, drains on out_ch handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (go && in_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && in_last_r) begin
      out_res_r <= verdict;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.valid_res  = out_res_r.valid_res;
  assign out_ch.error_kind = out_res_r.error_kind;

endmodule
